/* src/napa_pkg.sv */
// Package for the dynamic NAT port allocator: shared constants, codes and structs.
// Used by every module of the block except napa_ram; depends on nothing.
`timescale 1ns / 1ps
package napa_pkg;

  localparam int NUM_THREADS_DEF     = 4;
  localparam int MAX_EXTERNAL_DEF    = 16;
  localparam int MAX_SLICE_PORTS_DEF = 4096;

  localparam int WORD_BITS = 64;
  localparam int HASH_W    = 32;
  localparam int NADDR_W   = 5;
  localparam int COUNT_W   = 13;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_EXT    = 2'd0;
  localparam logic [1:0] REG_EXT_BASE   = 2'd1;
  localparam logic [1:0] REG_SLICE_BASE = 2'd2;
  localparam logic [1:0] REG_SLICE_CNT  = 2'd3;

  localparam logic [NADDR_W-1:0] NUM_EXT_RST    = 5'd1;
  localparam logic [31:0]        EXT_BASE_RST   = 32'd0;
  localparam logic [15:0]        SLICE_BASE_RST = 16'd1024;
  localparam logic [COUNT_W-1:0] SLICE_CNT_RST  = 13'd4096;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_e;

  // Result of the serial modulo unit.
  typedef struct packed {
    logic               done;
    logic [NADDR_W-1:0] rem;
  } mod_stat_t;

  // Result of one bitmap word scan.
  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } scan_res_t;

endpackage

/* src/napa_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module napa_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/napa_hash_mod.sv */
// Serial remainder unit: reduces the 32-bit flow hash modulo the pool size,
// one hash bit per cycle. Depends on napa_pkg.
`timescale 1ns / 1ps
module napa_hash_mod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [napa_pkg::HASH_W-1:0]         hash_i,
  input  logic [napa_pkg::NADDR_W-1:0]        div_i,
  output napa_pkg::mod_stat_t                 stat_o
);

  localparam int CntW = $clog2(napa_pkg::HASH_W);

  logic [napa_pkg::HASH_W-1:0]  hash_q;
  logic [napa_pkg::NADDR_W-1:0] div_q, rem_q;
  logic [CntW-1:0]              cnt_q;
  logic                         busy_q, done_q;
  logic [napa_pkg::NADDR_W:0]   trial;

  // Shift in the next hash bit, subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, hash_q[napa_pkg::HASH_W-1]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(napa_pkg::HASH_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(napa_pkg::HASH_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hash_q <= hash_i;
      div_q  <= div_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      hash_q <= hash_q << 1;
      rem_q  <= trial[napa_pkg::NADDR_W-1:0];
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

/* src/napa_word_scan.sv */
// Finds the lowest clear bit of a 64-bit bitmap word inside a bit window.
// Depends on napa_pkg.
`timescale 1ns / 1ps
module napa_word_scan (
  input  logic [napa_pkg::WORD_BITS-1:0] word_i,
  input  logic                           lo_en_i,
  input  logic [5:0]                     lo_off_i,
  input  logic                           hi_en_i,
  input  logic [5:0]                     hi_off_i,
  output napa_pkg::scan_res_t            res_o
);

  logic [napa_pkg::WORD_BITS-1:0] lo_mask, hi_mask, cand;

  always_comb begin
    lo_mask = lo_en_i ? ({napa_pkg::WORD_BITS{1'b1}} << lo_off_i)
                      : {napa_pkg::WORD_BITS{1'b1}};
    hi_mask = hi_en_i ? ({napa_pkg::WORD_BITS{1'b1}} >> (6'd63 - hi_off_i))
                      : {napa_pkg::WORD_BITS{1'b1}};
    cand    = ~word_i & lo_mask & hi_mask;
    res_o.found = |cand;
    res_o.pos   = '0;
    for (int i = napa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.pos = 6'(i);
      end
    end
  end

endmodule

/* src/nat_dynamic_port_allocator_core.sv */
// Dynamic source NAT port allocator. A free reads and then clears its bitmap word; an allocate
// first reduces the flow hash modulo the pool size, one hash bit per cycle, then for each address
// tried reads its hint and reads and checks 64-bit bitmap words until a clear bit is found.
// The next transaction can be accepted once its predecessor's result is in the output register.
// After reset a clearing pass writes all 4096 bitmap entries, one per cycle, and no request is
// accepted until it ends. Depends on napa_pkg, napa_ram, napa_hash_mod and napa_word_scan.
`timescale 1ns / 1ps
module nat_dynamic_port_allocator_core #(
  parameter int NUM_THREADS     = napa_pkg::NUM_THREADS_DEF,
  parameter int MAX_EXTERNAL    = napa_pkg::MAX_EXTERNAL_DEF,
  parameter int MAX_SLICE_PORTS = napa_pkg::MAX_SLICE_PORTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: thread_slot[1:0], src_addr_word[33:2], src_port_word[49:34],
  // protocol_num[57:50], free_ext_index[61:58], free_port[77:62], zero pad.
  input  logic [79:0] s_axis_tdata,
  // req_type.
  input  logic        s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: ext_addr[31:0], ext_index[35:32], alloc_port[51:36], zero pad.
  output logic [55:0] m_axis_tdata,
  // status.
  output logic [1:0]  m_axis_tuser
);

  // Widths of the map index (thread, address) and of bit and word positions.
  localparam int TW  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int EW  = (MAX_EXTERNAL > 1) ? $clog2(MAX_EXTERNAL) : 1;
  localparam int MW  = TW + EW;
  localparam int BW  = $clog2(MAX_SLICE_PORTS);
  localparam int WW  = (BW > 6) ? BW - 6 : 1;
  localparam int CW  = $clog2(MAX_SLICE_PORTS + 1);
  localparam int BAW = MW + WW;
  localparam int NW  = napa_pkg::NADDR_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CLEAR = 10'b00_0000_0010,
    S_MOD   = 10'b00_0000_0100,
    S_HRD   = 10'b00_0000_1000,
    S_HCHK  = 10'b00_0001_0000,
    S_WRD   = 10'b00_0010_0000,
    S_WCHK  = 10'b00_0100_0000,
    S_FRD   = 10'b00_1000_0000,
    S_FCHK  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [NW-1:0]                num_ext_q;
  logic [31:0]                  ext_base_q;
  logic [15:0]                  slice_base_q;
  logic [napa_pkg::COUNT_W-1:0] slice_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ext_q    <= napa_pkg::NUM_EXT_RST;
      ext_base_q   <= napa_pkg::EXT_BASE_RST;
      slice_base_q <= napa_pkg::SLICE_BASE_RST;
      slice_cnt_q  <= napa_pkg::SLICE_CNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        napa_pkg::REG_NUM_EXT:    num_ext_q    <= cfg_data_i[NW-1:0];
        napa_pkg::REG_EXT_BASE:   ext_base_q   <= cfg_data_i;
        napa_pkg::REG_SLICE_BASE: slice_base_q <= cfg_data_i[15:0];
        napa_pkg::REG_SLICE_CNT:  slice_cnt_q  <= cfg_data_i[napa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pool size and slice size, saturated to the built capacity.
  logic [NW-1:0] n_eff;
  logic [CW-1:0] count_eff, count_m1;
  logic [WW-1:0] last_w;

  assign n_eff     = (32'(num_ext_q) > MAX_EXTERNAL) ? NW'(MAX_EXTERNAL) : num_ext_q;
  assign count_eff = (32'(slice_cnt_q) > MAX_SLICE_PORTS) ? CW'(MAX_SLICE_PORTS)
                                                          : CW'(slice_cnt_q);
  assign count_m1  = count_eff - 1'b1;
  assign last_w    = WW'(count_m1 >> 6);

  // Request fields.
  logic        in_req;
  logic [1:0]  in_thr;
  logic [31:0] in_addr;
  logic [15:0] in_sport;
  logic [7:0]  in_proto;
  logic [3:0]  in_fidx;
  logic [15:0] in_fport;

  assign in_req   = s_axis_tuser;
  assign in_thr   = s_axis_tdata[1:0];
  assign in_addr  = s_axis_tdata[33:2];
  assign in_sport = s_axis_tdata[49:34];
  assign in_proto = s_axis_tdata[57:50];
  assign in_fidx  = s_axis_tdata[61:58];
  assign in_fport = s_axis_tdata[77:62];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [napa_pkg::HASH_W-1:0] hash;
  assign hash = in_addr ^ {in_sport, 16'd0} ^ {16'd0, in_proto, 8'd0};

  // Slice start of the incoming thread, used to place a freed port.
  logic [15:0] in_start, in_off;
  logic        thr_ok, alloc_bad, free_bad;

  assign in_start  = 16'(32'(slice_base_q) + 32'(in_thr) * 32'(count_eff));
  assign in_off    = in_fport - in_start;
  assign thr_ok    = 32'(in_thr) < NUM_THREADS;
  assign alloc_bad = !thr_ok || (n_eff == '0) || (count_eff == '0);
  assign free_bad  = !thr_ok || (NW'(in_fidx) >= n_eff) ||
                     (32'(in_off) >= 32'(count_eff));

  // Working registers of the transaction in flight.
  logic [1:0]    thr_q;
  logic [NW-1:0] idx_q, idx_d, k_q, k_d;
  logic [BW-1:0] lo_q, lo_d, bit_q, bit_d;
  logic [WW-1:0] w_q, w_d;
  logic          ph1_q, ph1_d;
  logic [BAW-1:0] clr_q;

  // Staged result.
  logic [1:0]  res_st_q, res_st_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [3:0]  res_idx_q, res_idx_d;
  logic [15:0] res_port_q, res_port_d;

  logic [MW-1:0] map;
  assign map = {TW'(thr_q), EW'(idx_q)};

  // Remainder unit.
  napa_pkg::mod_stat_t mod_stat;

  napa_hash_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && (in_req == napa_pkg::REQ_ALLOC) && !alloc_bad),
    .hash_i (hash),
    .div_i  (n_eff),
    .stat_o (mod_stat)
  );

  // Bitmap RAM: one 64-bit word per (thread, address, word) and hint RAM per map.
  logic [BAW-1:0]                 bm_addr;
  logic                           bm_we;
  logic [napa_pkg::WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic [MW-1:0]                  hn_addr;
  logic                           hn_we;
  logic [BW-1:0]                  hn_wdata, hn_rdata;

  napa_ram #(.Width(napa_pkg::WORD_BITS), .Depth(2 ** BAW)) u_bitmap (
    .clk_i  (clk_i),
    .addr_i (bm_addr),
    .we_i   (bm_we),
    .wdata_i(bm_wdata),
    .rdata_o(bm_rdata)
  );

  napa_ram #(.Width(BW), .Depth(2 ** MW)) u_hint (
    .clk_i  (clk_i),
    .addr_i (hn_addr),
    .we_i   (hn_we),
    .wdata_i(hn_wdata),
    .rdata_o(hn_rdata)
  );

  // Word scan over the current window [lo, count).
  napa_pkg::scan_res_t scan;

  napa_word_scan u_scan (
    .word_i  (bm_rdata),
    .lo_en_i (w_q == WW'(lo_q >> 6)),
    .lo_off_i(lo_q[5:0]),
    .hi_en_i (w_q == last_w),
    .hi_off_i(count_m1[5:0]),
    .res_o   (scan)
  );

  logic [BW-1:0] found_bit;
  logic [31:0]   next_hint;
  logic [15:0]   thr_start;
  logic [NW-1:0] idx_inc;

  assign found_bit = BW'({w_q, scan.pos});
  assign next_hint = 32'({w_q, scan.pos}) + 32'd1;
  assign thr_start = 16'(32'(slice_base_q) + 32'(thr_q) * 32'(count_eff));
  assign idx_inc   = ((idx_q + 1'b1) == n_eff) ? '0 : idx_q + 1'b1;

  // Memory port control.
  always_comb begin
    bm_addr  = {map, w_q};
    bm_we    = 1'b0;
    bm_wdata = bm_rdata;
    hn_addr  = map;
    hn_we    = 1'b0;
    hn_wdata = (next_hint == 32'(count_eff)) ? '0 : BW'(next_hint);
    case (state_q)
      S_CLEAR: begin
        bm_addr  = clr_q;
        bm_we    = 1'b1;
        bm_wdata = '0;
        hn_addr  = clr_q[MW-1:0];
        hn_we    = 1'b1;
        hn_wdata = '0;
      end
      S_WCHK: begin
        bm_we    = scan.found;
        bm_wdata = bm_rdata | ({{(napa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << scan.pos);
        hn_we    = scan.found;
      end
      S_FRD: begin
        bm_addr = {map, WW'(bit_q >> 6)};
      end
      S_FCHK: begin
        bm_addr  = {map, WW'(bit_q >> 6)};
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~({{(napa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_q[5:0]);
      end
      default: ;
    endcase
  end

  // Sequencer: hash remainder, then per address a hint read and a word-by-word
  // search from the hint to the end of the slice, then once from zero.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    k_d        = k_q;
    lo_d       = lo_q;
    bit_d      = bit_q;
    w_d        = w_q;
    ph1_d      = ph1_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_idx_d  = res_idx_q;
    res_port_d = res_port_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_st_d   = napa_pkg::ST_OK;
          res_addr_d = '0;
          res_idx_d  = '0;
          res_port_d = '0;
          if (in_req == napa_pkg::REQ_ALLOC) begin
            if (alloc_bad) begin
              res_st_d = napa_pkg::ST_EXHAUSTED;
              state_d  = S_OUT;
            end else begin
              state_d = S_MOD;
            end
          end else if (free_bad) begin
            res_st_d = napa_pkg::ST_BAD_FREE;
            state_d  = S_OUT;
          end else begin
            idx_d   = NW'(in_fidx);
            bit_d   = BW'(in_off);
            state_d = S_FRD;
          end
        end
      end
      S_CLEAR: begin
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_stat.done) begin
          idx_d   = mod_stat.rem;
          k_d     = '0;
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        state_d = S_HCHK;
      end
      S_HCHK: begin
        if (32'(hn_rdata) < 32'(count_eff)) begin
          lo_d  = hn_rdata;
          ph1_d = (hn_rdata != '0);
        end else begin
          lo_d  = '0;
          ph1_d = 1'b0;
        end
        w_d     = (32'(hn_rdata) < 32'(count_eff)) ? WW'(hn_rdata >> 6) : '0;
        state_d = S_WRD;
      end
      S_WRD: begin
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if (scan.found) begin
          bit_d      = found_bit;
          res_addr_d = ext_base_q + 32'(idx_q);
          res_idx_d  = 4'(idx_q);
          res_port_d = 16'(32'(thr_start) + 32'(found_bit));
          state_d    = S_OUT;
        end else if (w_q != last_w) begin
          w_d     = w_q + 1'b1;
          state_d = S_WRD;
        end else if (ph1_q) begin
          ph1_d   = 1'b0;
          lo_d    = '0;
          w_d     = '0;
          state_d = S_WRD;
        end else if ((k_q + 1'b1) == n_eff) begin
          res_st_d = napa_pkg::ST_EXHAUSTED;
          state_d  = S_OUT;
        end else begin
          k_d     = k_q + 1'b1;
          idx_d   = idx_inc;
          state_d = S_HRD;
        end
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      thr_q <= in_thr;
    end
    idx_q      <= idx_d;
    k_q        <= k_d;
    lo_q       <= lo_d;
    bit_q      <= bit_d;
    w_q        <= w_d;
    ph1_q      <= ph1_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_idx_q  <= res_idx_d;
    res_port_q <= res_port_d;
  end

  // Output register: a finished result waits here while the next transaction starts.
  logic        m_valid_q;
  logic [1:0]  m_st_q;
  logic [51:0] m_data_q;
  logic        load_out;

  assign load_out = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_st_q   <= res_st_q;
      m_data_q <= {res_port_q, res_idx_q, res_addr_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tdata  = {4'd0, m_data_q};

  // The clearing pass must finish before any request is taken.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during bitmap clearing");

  // The remainder unit reports only while the sequencer waits for it.
  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_stat.done |-> (state_q == S_MOD))
    else $error("remainder done outside its wait state");

  // A bitmap write happens only in the clearing pass, when a search hit sets a bit or when a free clears one.
  a_bm_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bm_we |-> (state_q == S_CLEAR || state_q == S_FCHK ||
               (state_q == S_WCHK && scan.found)))
    else $error("unexpected bitmap write");

  // A successful allocate always records the new hint with the bitmap word.
  a_hint_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCHK) |-> (hn_we == bm_we))
    else $error("hint and bitmap writes out of step");

  // Every accepted transaction leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction dropped");

endmodule

/* tb/sv/nat_dynamic_port_allocator_core_test.sv */
// Self-checking testbench for nat_dynamic_port_allocator_core: directed and random
// allocate/free traffic across several pool and slice settings, with a local predictor.
// Depends on napa_pkg and the RTL of the allocator.
`timescale 1ns / 1ps
module nat_dynamic_port_allocator_core_test;

  // One request as it travels on the request stream.
  typedef struct {
    logic        req;
    logic [1:0]  thr;
    logic [31:0] addr;
    logic [15:0] sport;
    logic [7:0]  proto;
    logic [3:0]  fidx;
    logic [15:0] fport;
  } napt_req_t;

  // One result as it comes back on the result stream.
  typedef struct {
    napa_pkg::status_e status;
    logic [31:0]       ext_addr;
    logic [3:0]        ext_index;
    logic [15:0]       port;
  } napt_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = napa_pkg::REG_NUM_EXT;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = napa_pkg::REQ_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Requests waiting to be driven, and results the predictor says must come back.
  napt_req_t pending_reqs[$];
  napt_res_t expected_res[$];
  napt_req_t req_on_bus;

  // Local copy of the configuration registers.
  int unsigned cfg_naddr = 1;
  int unsigned cfg_base  = 0;
  int unsigned cfg_sbase = 1024;
  int unsigned cfg_cnt   = 4096;

  // Local copy of the allocator state: one busy bitmap and one hint per thread/address.
  bit [4095:0] busy_map[64];
  int unsigned next_hint[64];

  // Idle pacing. When steady_* is set the side never idles.
  bit steady_src = 1'b0;
  bit steady_snk = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  int n_errors = 0;
  int n_checked = 0;
  int n_ok = 0;
  int n_exhausted = 0;
  int n_bad_free = 0;
  int n_phases = 0;

  nat_dynamic_port_allocator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(80, 15);
  endfunction

  function automatic int unsigned eff_count();
    return (cfg_cnt > 4096) ? 4096 : cfg_cnt;
  endfunction

  function automatic int unsigned eff_naddr();
    return (cfg_naddr > 16) ? 16 : cfg_naddr;
  endfunction

  function automatic int unsigned slice_first_port(int unsigned thr);
    return (cfg_sbase + thr * eff_count()) & 32'hFFFF;
  endfunction

  // Works out the result of one request and updates the local state as the block would.
  function automatic napt_res_t napt_allocate_or_free(napt_req_t rq);
    napt_res_t   r;
    int unsigned cnt, n, h, pref, idx, map, pos, start, off;
    bit          hit;
    r.status = napa_pkg::ST_OK;
    r.ext_addr = '0;
    r.ext_index = '0;
    r.port = '0;
    cnt = eff_count();
    n = eff_naddr();
    start = slice_first_port(rq.thr);
    hit = 1'b0;
    if (rq.req == napa_pkg::REQ_ALLOC) begin
      r.status = napa_pkg::ST_EXHAUSTED;
      if (n != 0 && cnt != 0) begin
        h = rq.addr ^ {rq.sport, 16'h0000} ^ {16'h0000, rq.proto, 8'h00};
        pref = h % n;
        for (int k = 0; k < n && !hit; k++) begin
          idx = (pref + k) % n;
          map = rq.thr * 16 + idx;
          pos = cnt;
          // Search from the hint to the end, then wrap once to zero.
          for (int j = next_hint[map]; j < cnt && pos == cnt; j++)
            if (!busy_map[map][j]) pos = j;
          for (int j = 0; j < cnt && pos == cnt; j++)
            if (!busy_map[map][j]) pos = j;
          if (pos < cnt) begin
            busy_map[map][pos] = 1'b1;
            next_hint[map] = (pos + 1) % cnt;
            r.status = napa_pkg::ST_OK;
            r.ext_addr = cfg_base + idx;
            r.ext_index = 4'(idx);
            r.port = 16'(start + pos);
            hit = 1'b1;
          end
        end
      end
    end else begin
      off = (rq.fport - start) & 32'hFFFF;
      if (rq.fidx >= n || off >= cnt) r.status = napa_pkg::ST_BAD_FREE;
      else busy_map[rq.thr * 16 + rq.fidx][off] = 1'b0;
    end
    return r;
  endfunction

  // Request driver: holds a transaction until it is accepted, then paces the next one.
  always @(posedge clk_i) begin
    logic nv;
    napt_res_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        r = napt_allocate_or_free(req_on_bus);
        expected_res.push_back(r);
        nv = 1'b0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_reqs.size() > 0) begin
          req_on_bus = pending_reqs.pop_front();
          s_axis_tdata <= {2'b00, req_on_bus.fport, req_on_bus.fidx, req_on_bus.proto,
                           req_on_bus.sport, req_on_bus.addr, req_on_bus.thr};
          s_axis_tuser <= req_on_bus.req;
          nv = 1'b1;
          src_gap = steady_src ? 0 : pick_gap();
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Result monitor: random back-pressure, and every accepted transaction is checked
  // against the oldest expectation.
  always @(posedge clk_i) begin
    napt_res_t e;
    logic nr;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result: status %0d", m_axis_tuser);
          n_errors++;
        end else begin
          e = expected_res.pop_front();
          n_checked++;
          case (e.status)
            napa_pkg::ST_OK:        n_ok++;
            napa_pkg::ST_EXHAUSTED: n_exhausted++;
            default:                n_bad_free++;
          endcase
          if (m_axis_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[31:0] !== e.ext_addr) begin
            $error("ext_addr: expected %h, got %h", e.ext_addr, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[35:32] !== e.ext_index) begin
            $error("ext_index: expected %0d, got %0d", e.ext_index, m_axis_tdata[35:32]);
            n_errors++;
          end
          if (m_axis_tdata[51:36] !== e.port) begin
            $error("alloc_port: expected %0d, got %0d", e.port, m_axis_tdata[51:36]);
            n_errors++;
          end
        end
      end
      if (steady_snk) begin
        nr = 1'b1;
      end else if (snk_gap > 0) begin
        snk_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        snk_gap = pick_gap();
      end
      m_axis_tready <= nr;
    end
  end

  task automatic push_req(logic req, logic [1:0] thr, logic [31:0] addr, logic [15:0] sport,
                          logic [7:0] proto, logic [3:0] fidx, logic [15:0] fport);
    napt_req_t rq;
    rq.req = req;
    rq.thr = thr;
    rq.addr = addr;
    rq.sport = sport;
    rq.proto = proto;
    rq.fidx = fidx;
    rq.fport = fport;
    pending_reqs.push_back(rq);
  endtask

  task automatic push_alloc(logic [1:0] thr);
    push_req(napa_pkg::REQ_ALLOC, thr, $urandom, 16'($urandom), 8'($urandom),
             4'($urandom), 16'($urandom));
  endtask

  // A free of a port that lies in the slice.
  task automatic push_good_free(logic [1:0] thr);
    int unsigned n, cnt;
    n = eff_naddr();
    cnt = eff_count();
    push_req(napa_pkg::REQ_FREE, thr, $urandom, 16'($urandom), 8'($urandom),
             4'((n == 0) ? $urandom_range(15) : $urandom_range(n - 1)),
             16'((cnt == 0) ? $urandom : slice_first_port(thr) + $urandom_range(cnt - 1)));
  endtask

  // Waits at falling edges, away from the clocked blocks, until nothing is in flight.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0);
  endtask

  // Writes all four registers back to back while the block is idle.
  task automatic set_config(int unsigned naddr, int unsigned base, int unsigned sbase,
                            int unsigned cnt);
    logic [31:0] vals[4];
    logic [1:0]  regs[4];
    wait_idle();
    vals = '{naddr & 32'h1F, base, sbase & 32'hFFFF, cnt & 32'h1FFF};
    regs = '{napa_pkg::REG_NUM_EXT, napa_pkg::REG_EXT_BASE, napa_pkg::REG_SLICE_BASE,
             napa_pkg::REG_SLICE_CNT};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_naddr = vals[0];
    cfg_base = vals[1];
    cfg_sbase = vals[2];
    cfg_cnt = vals[3];
    n_phases++;
  endtask

  initial begin
    int unsigned naddr, cnt, r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: one address, slices of 4096 ports from 1024.
    push_req(napa_pkg::REQ_ALLOC, 2'd0, 32'h0, 16'h0, 8'h0, 4'h0, 16'h0);
    push_req(napa_pkg::REQ_ALLOC, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 4'hF, 16'hFFFF);
    push_req(napa_pkg::REQ_ALLOC, 2'd1, 32'h1234_5678, 16'h8000, 8'h06, 4'h0, 16'h0);
    push_req(napa_pkg::REQ_FREE, 2'd0, 32'h0, 16'h0, 8'h0, 4'h0, 16'd1024);   // in use, freed
    push_req(napa_pkg::REQ_FREE, 2'd0, 32'h0, 16'h0, 8'h0, 4'hF, 16'd1024);   // index beyond pool
    push_req(napa_pkg::REQ_FREE, 2'd0, 32'h0, 16'h0, 8'h0, 4'h0, 16'd1023);   // just below slice
    push_req(napa_pkg::REQ_FREE, 2'd3, 32'h0, 16'h0, 8'h0, 4'h0, 16'hFFFF);   // above slice
    push_req(napa_pkg::REQ_ALLOC, 2'd0, 32'hA5A5_A5A5, 16'h5A5A, 8'h11, 4'h0, 16'h0);

    // Tiny slices, two addresses: run the pool dry, free one, allocate again.
    set_config(2, 32'hFFFF_FFFF, 16'hFFFE, 3);
    for (int i = 0; i < 8; i++) push_alloc(2'd0);
    push_req(napa_pkg::REQ_FREE, 2'd0, 32'h0, 16'h0, 8'h0, 4'h1, 16'h0000);
    push_alloc(2'd0);
    push_req(napa_pkg::REQ_ALLOC, 2'd2, 32'h0, 16'h0, 8'h0, 4'h0, 16'h0);

    // Zero count disables allocation; zero pool size rejects every request.
    set_config(5, 32'h0, 16'h0, 0);
    push_alloc(2'd1);
    push_good_free(2'd1);
    set_config(0, 32'h0, 16'h0, 64);
    push_alloc(2'd1);
    push_req(napa_pkg::REQ_FREE, 2'd1, 32'h0, 16'h0, 8'h0, 4'h0, 16'd64);

    // Saturated pool size and count, then a shrink that leaves hints and bits beyond it.
    set_config(31, 32'h8000_0000, 16'hFFFF, 8191);
    for (int i = 0; i < 4; i++) push_alloc(2'($urandom));
    set_config(1, 32'h10, 16'd100, 64);
    for (int i = 0; i < 10; i++) push_alloc(2'd1);
    set_config(1, 32'h10, 16'd100, 4);
    for (int i = 0; i < 6; i++) push_alloc(2'd1);

    // Random phases: well-formed traffic mostly, with stray frees mixed in.
    for (int p = 0; p < 11; p++) begin
      r = $urandom_range(9);
      naddr = (r < 3) ? 1 : (r < 6) ? $urandom_range(4, 2) : (r < 8) ? 16 : $urandom_range(31);
      r = $urandom_range(9);
      cnt = (r < 6) ? $urandom_range(16, 1) : (r < 8) ? $urandom_range(200, 17)
          : (r < 9) ? 4096 : $urandom_range(8191);
      steady_src = (p % 4 == 1);
      steady_snk = (p % 4 == 2);
      set_config(naddr, $urandom, $urandom, cnt);
      for (int i = 0; i < 66; i++) begin
        r = $urandom_range(99);
        if (r < 55) push_alloc(2'($urandom));
        else if (r < 90) push_good_free(2'($urandom));
        else push_req(napa_pkg::REQ_FREE, 2'($urandom), $urandom, 16'($urandom),
                      8'($urandom), 4'($urandom), 16'($urandom));
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d results over %0d register settings: %0d allocated,",
             n_checked, n_phases + 1, n_ok);
    $display("  %0d exhausted, %0d rejected frees; %0d mismatches.",
             n_exhausted, n_bad_free, n_errors);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run, including the clearing pass after reset.
  initial begin
    #100_000_000;
    $display("Timed out with %0d results outstanding.", expected_res.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
